FILE: rtl/manipulator_jacobian_torque_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the manipulator Jacobian torque unit
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MANIPULATOR_JACOBIAN_TORQUE_UNIT_MACROS_SVH
`define MANIPULATOR_JACOBIAN_TORQUE_UNIT_MACROS_SVH

// property must hold at every edge out of reset
`define MJT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define MJT_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/mjt_pkg.sv
// ----------------------------------------------------------------------------
// mjt_pkg
// Shared widths, codes and saturation helper for the Jacobian torque unit.
// ----------------------------------------------------------------------------
package mjt_pkg;

    localparam int DATA_W      = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int LINK_ENTRIES = 12;
    localparam int JAC_ROWS    = 6;

    localparam logic [1:0] CMD_LOAD_LINK   = 2'd0;
    localparam logic [1:0] CMD_LOAD_WRENCH = 2'd1;
    localparam logic [1:0] CMD_COMPUTE     = 2'd2;

    localparam logic REG_JOINT_COUNT = 1'b0;
    localparam logic REG_OUTPUT_MODE = 1'b1;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/manipulator_jacobian_torque_unit.sv
// Loads (link transform or wrench entry) are written only while the sequencer is idle.
// Compute chains the link transforms and builds the Jacobian, then emits either
// one torque per joint or every Jacobian entry, waiting out any output stalls.
// Every multiply goes through one shared 32x32 multiplier.
// The input is not ready from compute accept until the last result transfer.
// Reset (aresetn, synchronous): joint_count 6, output_mode 0, sequencer idle.
// ----------------------------------------------------------------------------
// manipulator_jacobian_torque_unit
// Chains link transforms, builds the geometric Jacobian and emits J^T*wrench
// or the Jacobian itself, all over one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module manipulator_jacobian_torque_unit #(
    parameter int MAX_JOINTS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // joint[2:0], entry[6:3], value[38:7]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_value[31:0], result_joint[34:32], result_row[37:35]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int JW         = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int LINK_DEPTH = MAX_JOINTS * mjt_pkg::LINK_ENTRIES;
    localparam int JAC_DEPTH  = MAX_JOINTS * mjt_pkg::JAC_ROWS;
    localparam int LA_W       = $clog2(LINK_DEPTH);
    localparam int JA_W       = $clog2(JAC_DEPTH);
    localparam int ACC_W      = 64 - FRAC_BITS + 3;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_COPY_RD, S_COPY_WR,
        S_CH_RD, S_CH_MUL, S_CH_ACC, S_CH_WR,
        S_PEND_RD, S_PEND_WR, S_J_START, S_ZP_RD, S_ZP_WR,
        S_CX_MUL, S_CX_ACC, S_CX_WR, S_ZW,
        S_TQ_RD, S_TQ_MUL, S_TQ_ACC, S_TQ_OUT,
        S_EM_RD, S_EM_LD, S_EM_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [JW-1:0] j_reg, j_next, nm1_reg, nm1_next;
    logic [2:0] r_reg, r_next, k_reg, k_next;
    logic [1:0] c_reg, c_next;
    logic [3:0] ent_reg, ent_next;
    logic [3:0] jc_reg, jc_next;
    logic mode_reg, mode_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg;
    logic signed [31:0] z_reg [3];
    logic signed [31:0] z_next [3];
    logic signed [31:0] d_reg [3];
    logic signed [31:0] d_next [3];
    logic signed [31:0] pend_reg [3];
    logic signed [31:0] pend_next [3];
    logic signed [31:0] wrench_reg [6];
    logic m_tvalid_reg, m_tvalid_next, m_tlast_reg, m_tlast_next;
    logic [39:0] m_tdata_reg, m_tdata_next;

    logic signed [31:0] link_mem [LINK_DEPTH];
    logic signed [31:0] chain_mem [LINK_DEPTH];
    logic signed [31:0] jac_mem [JAC_DEPTH];
    logic signed [31:0] link_rd_reg, chain_rd_reg, jac_rd_reg;

    logic [LA_W-1:0] link_raddr, link_waddr, chain_raddr, chain_waddr;
    logic [JA_W-1:0] jac_raddr, jac_waddr;
    logic link_we, chain_we, jac_we, wrench_we;
    logic signed [31:0] chain_wdata, jac_wdata;
    logic signed [31:0] op_a, op_b;
    logic signed [ACC_W-1:0] term;
    logic [1:0] za_idx, db_idx, zw_idx;

    logic [2:0] in_joint;
    logic [3:0] in_entry;
    logic signed [31:0] in_value;

    assign in_joint  = s_tdata[2:0];
    assign in_entry  = s_tdata[6:3];
    assign in_value  = s_tdata[38:7];
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    assign term   = ACC_W'(prod_reg >>> FRAC_BITS);
    assign zw_idx = 2'(r_reg - 3'd3);

    always_comb begin
        unique case ({r_reg[1:0], k_reg[0]})
            3'b000:  begin za_idx = 2'd1; db_idx = 2'd2; end
            3'b001:  begin za_idx = 2'd2; db_idx = 2'd1; end
            3'b010:  begin za_idx = 2'd2; db_idx = 2'd0; end
            3'b011:  begin za_idx = 2'd0; db_idx = 2'd2; end
            3'b100:  begin za_idx = 2'd0; db_idx = 2'd1; end
            3'b101:  begin za_idx = 2'd1; db_idx = 2'd0; end
            default: begin za_idx = 2'd0; db_idx = 2'd0; end
        endcase
    end

    always_comb begin
        unique case (state_reg)
            S_CH_MUL: begin
                op_a = chain_rd_reg;
                if (k_reg < 3'd3) begin
                    op_b = link_rd_reg;
                end else begin
                    op_b = (c_reg == 2'd3) ? ONE : 32'sd0;
                end
            end
            S_CX_MUL: begin
                op_a = z_reg[za_idx];
                op_b = d_reg[db_idx];
            end
            S_TQ_MUL: begin
                op_a = jac_rd_reg;
                op_b = wrench_reg[k_reg];
            end
            default: begin
                op_a = 32'sd0;
                op_b = 32'sd0;
            end
        endcase
    end

    always_comb begin
        int n;
        int jm1;
        n             = 1;
        state_next    = state_reg;
        j_next        = j_reg;
        nm1_next      = nm1_reg;
        r_next        = r_reg;
        k_next        = k_reg;
        c_next        = c_reg;
        ent_next      = ent_reg;
        jc_next       = jc_reg;
        mode_next     = mode_reg;
        acc_next      = acc_reg;
        z_next        = z_reg;
        d_next        = d_reg;
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        link_we       = 1'b0;
        wrench_we     = 1'b0;
        chain_we      = 1'b0;
        jac_we        = 1'b0;
        link_waddr    = LA_W'(int'(in_joint) * mjt_pkg::LINK_ENTRIES + int'(in_entry));
        link_raddr    = '0;
        chain_raddr   = '0;
        chain_waddr   = '0;
        chain_wdata   = link_rd_reg;
        jac_raddr     = '0;
        jac_waddr     = '0;
        jac_wdata     = 32'sd0;
        jm1           = int'(j_reg) - 1;

        if (cfg_valid) begin
            if (cfg_index == mjt_pkg::REG_JOINT_COUNT) begin
                jc_next = cfg_data;
            end else begin
                mode_next = cfg_data[0];
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    priority if (s_tuser == mjt_pkg::CMD_LOAD_LINK) begin
                        link_we = (int'(in_joint) < MAX_JOINTS) && (in_entry < 4'd12);
                    end else if (s_tuser == mjt_pkg::CMD_LOAD_WRENCH) begin
                        wrench_we = (in_entry < 4'd6);
                    end else if (s_tuser == mjt_pkg::CMD_COMPUTE) begin
                        n = int'(jc_reg);
                        if (n < 1) begin
                            n = 1;
                        end
                        if (n > MAX_JOINTS) begin
                            n = MAX_JOINTS;
                        end
                        nm1_next   = JW'(n - 1);
                        ent_next   = 4'd0;
                        state_next = S_COPY_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_COPY_RD: begin
                link_raddr = LA_W'(ent_reg);
                state_next = S_COPY_WR;
            end
            S_COPY_WR: begin
                chain_we    = 1'b1;
                chain_waddr = LA_W'(ent_reg);
                chain_wdata = link_rd_reg;
                if (ent_reg == 4'd11) begin
                    r_next = 3'd0;
                    c_next = 2'd0;
                    k_next = 3'd0;
                    if (nm1_reg == '0) begin
                        state_next = S_PEND_RD;
                    end else begin
                        j_next     = JW'(1);
                        state_next = S_CH_RD;
                    end
                end else begin
                    ent_next   = ent_reg + 4'd1;
                    state_next = S_COPY_RD;
                end
            end
            S_CH_RD: begin
                chain_raddr = LA_W'(jm1 * 12 + int'(r_reg) * 4
                                    + ((k_reg < 3'd3) ? int'(k_reg) : 3));
                link_raddr  = LA_W'(int'(j_reg) * 12 + int'(c_reg)
                                    + ((k_reg < 3'd3) ? int'(k_reg) * 4 : 0));
                state_next  = S_CH_MUL;
            end
            S_CH_MUL: begin
                state_next = S_CH_ACC;
            end
            S_CH_ACC: begin
                acc_next = (k_reg == 3'd0) ? term : acc_reg + term;
                if (k_reg == 3'd3) begin
                    state_next = S_CH_WR;
                end else begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_CH_RD;
                end
            end
            S_CH_WR: begin
                chain_we    = 1'b1;
                chain_waddr = LA_W'(int'(j_reg) * 12 + int'(r_reg) * 4 + int'(c_reg));
                chain_wdata = mjt_pkg::sat32(64'(acc_reg));
                k_next      = 3'd0;
                state_next  = S_CH_RD;
                if (c_reg != 2'd3) begin
                    c_next = c_reg + 2'd1;
                end else begin
                    c_next = 2'd0;
                    if (r_reg != 3'd2) begin
                        r_next = r_reg + 3'd1;
                    end else begin
                        r_next = 3'd0;
                        if (j_reg == nm1_reg) begin
                            state_next = S_PEND_RD;
                        end else begin
                            j_next = j_reg + JW'(1);
                        end
                    end
                end
            end
            S_PEND_RD: begin
                chain_raddr = LA_W'(int'(nm1_reg) * 12 + int'(r_reg) * 4 + 3);
                state_next  = S_PEND_WR;
            end
            S_PEND_WR: begin
                pend_next[r_reg[1:0]] = chain_rd_reg;
                if (r_reg == 3'd2) begin
                    j_next     = '0;
                    state_next = S_J_START;
                end else begin
                    r_next     = r_reg + 3'd1;
                    state_next = S_PEND_RD;
                end
            end
            S_J_START: begin
                r_next = 3'd0;
                k_next = 3'd0;
                if (j_reg == '0) begin
                    z_next[0]  = 32'sd0;
                    z_next[1]  = 32'sd0;
                    z_next[2]  = ONE;
                    d_next     = pend_reg;
                    state_next = S_CX_MUL;
                end else begin
                    state_next = S_ZP_RD;
                end
            end
            S_ZP_RD: begin
                chain_raddr = LA_W'(jm1 * 12 + int'(r_reg) * 4 + ((k_reg == 3'd0) ? 2 : 3));
                state_next  = S_ZP_WR;
            end
            S_ZP_WR: begin
                if (k_reg == 3'd0) begin
                    z_next[r_reg[1:0]] = chain_rd_reg;
                    k_next             = 3'd1;
                    state_next         = S_ZP_RD;
                end else begin
                    d_next[r_reg[1:0]] = mjt_pkg::sat32(64'(pend_reg[r_reg[1:0]])
                                                        - 64'(chain_rd_reg));
                    k_next = 3'd0;
                    if (r_reg == 3'd2) begin
                        r_next     = 3'd0;
                        state_next = S_CX_MUL;
                    end else begin
                        r_next     = r_reg + 3'd1;
                        state_next = S_ZP_RD;
                    end
                end
            end
            S_CX_MUL: begin
                state_next = S_CX_ACC;
            end
            S_CX_ACC: begin
                acc_next = (k_reg == 3'd0) ? term : acc_reg - term;
                if (k_reg == 3'd1) begin
                    state_next = S_CX_WR;
                end else begin
                    k_next     = 3'd1;
                    state_next = S_CX_MUL;
                end
            end
            S_CX_WR: begin
                jac_we    = 1'b1;
                jac_waddr = JA_W'(int'(j_reg) * 6 + int'(r_reg));
                jac_wdata = mjt_pkg::sat32(64'(acc_reg));
                k_next    = 3'd0;
                if (r_reg == 3'd2) begin
                    r_next     = 3'd3;
                    state_next = S_ZW;
                end else begin
                    r_next     = r_reg + 3'd1;
                    state_next = S_CX_MUL;
                end
            end
            S_ZW: begin
                jac_we    = 1'b1;
                jac_waddr = JA_W'(int'(j_reg) * 6 + int'(r_reg));
                jac_wdata = z_reg[zw_idx];
                if (r_reg == 3'd5) begin
                    r_next = 3'd0;
                    k_next = 3'd0;
                    if (j_reg == nm1_reg) begin
                        j_next     = '0;
                        state_next = mode_reg ? S_EM_RD : S_TQ_RD;
                    end else begin
                        j_next     = j_reg + JW'(1);
                        state_next = S_J_START;
                    end
                end else begin
                    r_next = r_reg + 3'd1;
                end
            end
            S_TQ_RD: begin
                jac_raddr  = JA_W'(int'(j_reg) * 6 + int'(k_reg));
                state_next = S_TQ_MUL;
            end
            S_TQ_MUL: begin
                state_next = S_TQ_ACC;
            end
            S_TQ_ACC: begin
                acc_next = (k_reg == 3'd0) ? term : acc_reg + term;
                if (k_reg == 3'd5) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, 3'd0, 3'(j_reg),
                                     mjt_pkg::sat32(64'(acc_next))};
                    m_tlast_next  = (j_reg == nm1_reg);
                    state_next    = S_TQ_OUT;
                end else begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_TQ_RD;
                end
            end
            S_TQ_OUT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    k_next        = 3'd0;
                    if (j_reg == nm1_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        j_next     = j_reg + JW'(1);
                        state_next = S_TQ_RD;
                    end
                end
            end
            S_EM_RD: begin
                jac_raddr  = JA_W'(int'(j_reg) * 6 + int'(r_reg));
                state_next = S_EM_LD;
            end
            S_EM_LD: begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {2'b00, r_reg, 3'(j_reg), jac_rd_reg};
                m_tlast_next  = (j_reg == nm1_reg) && (r_reg == 3'd5);
                state_next    = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    state_next    = S_EM_RD;
                    if (r_reg == 3'd5) begin
                        r_next = 3'd0;
                        if (j_reg == nm1_reg) begin
                            state_next = S_IDLE;
                        end else begin
                            j_next = j_reg + JW'(1);
                        end
                    end else begin
                        r_next = r_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            jc_reg       <= 4'd6;
            mode_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            j_reg        <= '0;
            nm1_reg      <= '0;
            r_reg        <= 3'd0;
            k_reg        <= 3'd0;
            c_reg        <= 2'd0;
            ent_reg      <= 4'd0;
        end else begin
            state_reg    <= state_next;
            jc_reg       <= jc_next;
            mode_reg     <= mode_next;
            m_tvalid_reg <= m_tvalid_next;
            j_reg        <= j_next;
            nm1_reg      <= nm1_next;
            r_reg        <= r_next;
            k_reg        <= k_next;
            c_reg        <= c_next;
            ent_reg      <= ent_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        prod_reg    <= op_a * op_b;
        z_reg       <= z_next;
        d_reg       <= d_next;
        pend_reg    <= pend_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        if (wrench_we) begin
            wrench_reg[in_entry[2:0]] <= in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= in_value;
        end
        link_rd_reg <= link_mem[link_raddr];
    end

    always_ff @(posedge aclk) begin
        if (chain_we) begin
            chain_mem[chain_waddr] <= chain_wdata;
        end
        chain_rd_reg <= chain_mem[chain_raddr];
    end

    always_ff @(posedge aclk) begin
        if (jac_we) begin
            jac_mem[jac_waddr] <= jac_wdata;
        end
        jac_rd_reg <= jac_mem[jac_raddr];
    end

endmodule

FILE: rtl/mjt_checker.sv
// ----------------------------------------------------------------------------
// mjt_checker
// Port-level checks on the Jacobian torque unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "manipulator_jacobian_torque_unit_macros.svh"

module mjt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // no input taken while a result is on offer
    `MJT_NEVER(a_busy_overlap, aclk, aresetn, s_tready && m_tvalid, "input ready during output")
    `MJT_ASSERT(a_compute_busy, aclk, aresetn, (s_tvalid && s_tready && s_tuser == mjt_pkg::CMD_COMPUTE) |=> !s_tready, "ready right after compute")
    `MJT_ASSERT(a_last_ends, aclk, aresetn, (m_tvalid && m_tready && m_tlast) |=> !m_tvalid, "output after last transfer")
    `MJT_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "stalled output changed")

endmodule

bind manipulator_jacobian_torque_unit mjt_checker u_mjt_checker (.*);
